// File: rtl/ppt_pkg.sv
package ppt_pkg;

  localparam int PeriodW  = 32;
  localparam int SumW     = 33;
  localparam int ShaftW   = 31;
  localparam int EngineW  = 33;
  localparam int TickW    = 32;
  localparam int ReadW    = 16;
  localparam int ScaleW   = 9;
  localparam int DivW     = 49;
  localparam int CntW     = 6;
  localparam int InDataW  = 40;
  localparam int OutDataW = 240;

  localparam logic [ShaftW-1:0] ShaftNum  = 31'd1200000000;
  localparam logic [15:0]       TickUsecs = 16'd40000;

  localparam logic [1:0] ACT_EDGE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] REG_ENGINE_SCALE = 2'd0;
  localparam logic [1:0] REG_OUTPUT_SCALE = 2'd1;
  localparam logic [1:0] REG_TEST_MODE    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_POST = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef enum logic [5:0] {
    PH_SHAFT = 6'b000001,
    PH_ENG   = 6'b000010,
    PH_PTS   = 6'b000100,
    PH_PTE   = 6'b001000,
    PH_RD1   = 6'b010000,
    PH_RD2   = 6'b100000
  } phase_t;

  // (a - b) / 2, truncated toward zero
  function automatic logic [EngineW-1:0] half_diff(input logic [EngineW-1:0] a,
                                                   input logic [EngineW-1:0] b);
    logic [EngineW:0] d;
    logic [EngineW:0] h;
    d = {1'b0, a} - {1'b0, b};
    h = d + {{EngineW{1'b0}}, d[EngineW]};
    h = {h[EngineW], h[EngineW:1]};
    return h[EngineW-1:0];
  endfunction

  function automatic logic [TickW-1:0] tick_sat(input logic neg,
                                                input logic [DivW-1:0] q);
    logic [TickW-1:0] r;
    if (neg) begin
      if (q > DivW'(33'h080000000)) r = 32'h80000000;
      else r = TickW'(~q + DivW'(1));
    end else begin
      if (q > DivW'(32'h7FFFFFFF)) r = 32'h7FFFFFFF;
      else r = q[TickW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/pulse_period_tachometer_unit.sv
// Channel | Direction | Payload
// s_axis  | in        | tuser: action; tdata: pin_level, period_us, stop_request
// m_axis  | out       | tdata: eight result fields, see port comment
// cfg     | in        | plain register write, index 0..2
//
// One result per transfer in. Edge with pin_level low: four bit-serial
// divisions of 31, 40, 49 and 49 steps on the shared divider. Read: 34 or
// 74 division steps. Tick, stopped read and other items use no division.
// rst clears control and history state, not divider operands or m_axis_tdata.
// A new item is taken while a result still waits on m_axis; the block then
// holds its next result until that one is taken.
module pulse_period_tachometer_unit
  import ppt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          s_axis_tuser,   // action
  // pin_level[0], period_us[32:1], stop_request[33], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // last_period_us[31:0], shaft_rpm_tenths[62:32], engine_rpm_tenths[95:63],
  // shaft_delta_tenths[126:96], engine_delta_tenths[159:127],
  // shaft_delta_per_tick[191:160], engine_delta_per_tick[223:192],
  // rpm_read[239:224]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [ScaleW-1:0]   cfg_data
);

  state_t state;
  phase_t phase;

  logic [ScaleW-1:0]  engine_scale;
  logic [ScaleW-1:0]  output_scale;
  logic               test_mode;

  logic [PeriodW-1:0] period_newest;
  logic [PeriodW-1:0] period_older;
  logic [ShaftW-1:0]  shaft_h0, shaft_h1, shaft_h2;
  logic [EngineW-1:0] eng_h0, eng_h1, eng_h2;
  logic [ShaftW-1:0]  shaft_delta;
  logic [EngineW-1:0] eng_delta;
  logic [TickW-1:0]   shaft_tick;
  logic [TickW-1:0]   eng_tick;
  logic               edge_seen;
  logic [ReadW-1:0]   rd;

  logic [DivW-1:0]    quot;
  logic [SumW-1:0]    rem;
  logic [SumW-1:0]    divisor;
  logic [CntW-1:0]    cnt;
  logic               neg;

  logic [SumW-1:0]    sum;
  logic [SumW:0]      trial;
  logic               ge;
  logic [EngineW-1:0] mag_s, mag_e;
  logic [ReadW-1:0]   q_sat;
  logic               in_xfer;
  logic               out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    sum = {1'b0, period_newest} + {1'b0, period_older};
    if (sum == '0) sum = SumW'(1);
    trial = {rem, quot[DivW-1]};
    ge = trial >= {1'b0, divisor};
    mag_s = shaft_delta[ShaftW-1] ? EngineW'(-$signed(shaft_delta)) : EngineW'(shaft_delta);
    mag_e = eng_delta[EngineW-1] ? -eng_delta : eng_delta;
    q_sat = (quot > DivW'(16'hFFFF)) ? 16'hFFFF : quot[ReadW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_scale <= 9'd100;
      output_scale <= '0;
      test_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENGINE_SCALE: engine_scale <= cfg_data;
        REG_OUTPUT_SCALE: output_scale <= cfg_data;
        REG_TEST_MODE:    test_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_SHAFT;
      period_newest <= '0;
      period_older  <= '0;
      shaft_h0 <= '0; shaft_h1 <= '0; shaft_h2 <= '0;
      eng_h0   <= '0; eng_h1   <= '0; eng_h2   <= '0;
      shaft_delta   <= '0;
      eng_delta     <= '0;
      shaft_tick    <= '0;
      eng_tick      <= '0;
      edge_seen     <= 1'b0;
      rd            <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            rd <= '0;
            case (s_axis_tuser)
              ACT_EDGE: begin
                if (!s_axis_tdata[0]) begin
                  period_older  <= period_newest;
                  period_newest <= s_axis_tdata[32:1];
                  shaft_h1 <= shaft_h0; shaft_h2 <= shaft_h1;
                  eng_h1   <= eng_h0;   eng_h2   <= eng_h1;
                  edge_seen <= 1'b1;
                  phase <= PH_SHAFT;
                  state <= S_PREP;
                end else begin
                  state <= S_EMIT;
                end
              end
              ACT_TICK: begin
                if (!edge_seen) begin
                  shaft_h0 <= '0; shaft_h1 <= '0; shaft_h2 <= '0;
                  eng_h0   <= '0;
                end
                edge_seen <= 1'b0;
                state <= S_EMIT;
              end
              ACT_READ: begin
                if (!s_axis_tdata[33]) begin
                  phase <= PH_RD1;
                  state <= S_PREP;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_PREP: begin
          rem   <= '0;
          state <= S_DIV;
          case (phase)
            PH_SHAFT: begin
              quot <= {ShaftNum, 18'b0};
              divisor <= sum;
              cnt <= CntW'(31);
            end
            PH_ENG: begin
              quot <= {40'(shaft_h0) * 40'(engine_scale) + 40'd50, 9'b0};
              divisor <= SumW'(100);
              cnt <= CntW'(40);
            end
            PH_PTS: begin
              quot <= DivW'(mag_s) * DivW'(TickUsecs);
              neg  <= shaft_delta[ShaftW-1];
              divisor <= sum;
              cnt <= CntW'(49);
            end
            PH_PTE: begin
              quot <= DivW'(mag_e) * DivW'(TickUsecs);
              neg  <= eng_delta[EngineW-1];
              divisor <= sum;
              cnt <= CntW'(49);
            end
            PH_RD1: begin
              quot <= {{1'b0, eng_h0} + 34'd5, 15'b0};
              divisor <= SumW'(10);
              cnt <= CntW'(34);
            end
            PH_RD2: begin
              quot <= {40'(quot[29:0]) * 40'(output_scale) + 40'd50, 9'b0};
              divisor <= SumW'(100);
              cnt <= CntW'(40);
            end
            default: ;
          endcase
        end
        S_DIV: begin
          // one quotient bit per cycle
          quot <= {quot[DivW-2:0], ge};
          rem  <= ge ? SumW'(trial - {1'b0, divisor}) : trial[SumW-1:0];
          cnt  <= cnt - CntW'(1);
          if (cnt == CntW'(1)) state <= S_POST;
        end
        S_POST: begin
          case (phase)
            PH_SHAFT: begin
              shaft_h0    <= quot[ShaftW-1:0];
              shaft_delta <= ShaftW'(half_diff(EngineW'(quot[ShaftW-1:0]),
                                               EngineW'(shaft_h2)));
              phase <= PH_ENG;
              state <= S_PREP;
            end
            PH_ENG: begin
              eng_h0    <= quot[EngineW-1:0];
              eng_delta <= half_diff(quot[EngineW-1:0], eng_h2);
              phase <= PH_PTS;
              state <= S_PREP;
            end
            PH_PTS: begin
              shaft_tick <= tick_sat(neg, quot);
              phase <= PH_PTE;
              state <= S_PREP;
            end
            PH_PTE: begin
              eng_tick <= tick_sat(neg, quot);
              state <= S_EMIT;
            end
            PH_RD1: begin
              if (test_mode || output_scale == '0) begin
                rd    <= q_sat;
                state <= S_EMIT;
              end else begin
                phase <= PH_RD2;
                state <= S_PREP;
              end
            end
            PH_RD2: begin
              rd    <= q_sat;
              state <= S_EMIT;
            end
            default: state <= S_EMIT;
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tdata <= {rd, eng_tick, shaft_tick, eng_delta, shaft_delta,
                             eng_h0, shaft_h0, period_newest};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ppt_checker.sv
module ppt_checker
  import ppt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_shaft_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[62:32] <= 31'd1200000000)
    else $error("shaft rpm out of range");

endmodule

bind pulse_period_tachometer_unit ppt_checker u_ppt_checker (.*);
